/* design/hhve_pkg.sv */
// Shared types, constants and helpers for the HTTP header value extractor.
// Used by hhve_front, hhve_queue, hhve_back and http_header_value_extract_core.
`timescale 1ns / 1ps

package hhve_pkg;

  // Limits
  localparam int MAX_NAME = 8;
  localparam int MAX_LINE = 2048;
  localparam int POS_W    = 12;
  localparam int CNT_W    = 12;
  localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
  localparam logic [CNT_W-1:0] LINE_MAX = CNT_W'(MAX_LINE);
  localparam logic [3:0]       NLEN_MAX = 4'(MAX_NAME);

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Scan phases
  localparam logic [1:0] PH_SCAN    = 2'd0;
  localparam logic [1:0] PH_CONFIRM = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  // Status codes
  localparam logic [1:0] ST_FOUND      = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd2;

  // Result kinds
  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Characters
  localparam logic [7:0] CHR_CR  = 8'h0D;
  localparam logic [7:0] CHR_LF  = 8'h0A;
  localparam logic [7:0] CHR_SP  = 8'h20;
  localparam logic [7:0] CHR_TAB = 8'h09;

  // Register map
  localparam int          CFG_AW       = 4;
  localparam logic        REG_NAME_CHR = 1'b0;
  localparam logic        REG_NAME_LEN = 1'b1;
  localparam logic [63:0] NAME_CHR_RST = 64'd251061825352;
  localparam logic [3:0]  NAME_LEN_RST = 4'd5;

  // One result item
  typedef struct packed {
    logic             kind;
    logic [7:0]       vbyte;
    logic [1:0]       status;
    logic [CNT_W-1:0] vlen;
    logic             sat;
    logic             eor;
  } result_t;

  // Results of one accepted byte (one or two)
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  // Per-packet scanner state
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             nm;
    logic             skip;
    logic             inval;
    logic             cr;
    logic [CNT_W-1:0] vcnt;
    logic             vtrunc;
    logic [1:0]       phase;
  } scan_t;

  // State plus optional value byte after one line byte
  typedef struct packed {
    scan_t      s;
    logic       emit;
    logic [7:0] ch;
  } lb_t;

  // ASCII lower-case fold
  function automatic logic [7:0] fold(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // State at the start of a packet
  function automatic scan_t new_packet();
    scan_t s;
    s.pos    = '0;
    s.nm     = 1'b1;
    s.skip   = 1'b0;
    s.inval  = 1'b0;
    s.cr     = 1'b0;
    s.vcnt   = '0;
    s.vtrunc = 1'b0;
    s.phase  = PH_SCAN;
    return s;
  endfunction

endpackage

/* design/hhve_front.sv */
// Front end: holds the scanner state, classifies each accepted byte and
// builds the queue entry of its results. Depends on hhve_pkg.
`timescale 1ns / 1ps

module hhve_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [63:0]         name_chars,
  input  logic [3:0]          name_length,
  output logic                wr_en,
  output hhve_pkg::entry_t    wr_entry
);

  hhve_pkg::scan_t st_r, st_nxt;

  // Value byte emission with saturation at the line limit
  function automatic hhve_pkg::lb_t put_value(hhve_pkg::lb_t i);
    hhve_pkg::lb_t o;
    o = i;
    if (i.s.vcnt >= hhve_pkg::LINE_MAX) begin
      o.s.vtrunc = 1'b1;
    end else begin
      o.s.vcnt = i.s.vcnt + 1'b1;
      o.emit   = 1'b1;
    end
    return o;
  endfunction

  // One ordinary line byte
  function automatic hhve_pkg::lb_t line_byte(hhve_pkg::scan_t s, logic [7:0] c,
                                              logic [63:0] nchars, logic [3:0] nlen);
    hhve_pkg::lb_t o;
    logic          blank;
    logic [7:0]    want;
    o.s    = s;
    o.emit = 1'b0;
    o.ch   = c;
    blank  = (c == hhve_pkg::CHR_SP) || (c == hhve_pkg::CHR_TAB);
    want   = nchars[{s.pos[2:0], 3'b000} +: 8];
    if (s.inval) begin
      o = put_value(o);
    end else if (s.skip) begin
      if (!blank) begin
        o.s.skip  = 1'b0;
        o.s.inval = 1'b1;
        o = put_value(o);
      end
    end else if (s.nm) begin
      if (s.pos < {8'd0, nlen}) begin
        if (hhve_pkg::fold(c) != hhve_pkg::fold(want)) o.s.nm = 1'b0;
      end else if (blank) begin
        o.s.skip = 1'b1;
      end else begin
        o.s.inval = 1'b1;
        o = put_value(o);
      end
    end
    if (s.pos < hhve_pkg::POS_MAX) o.s.pos = s.pos + 1'b1;
    return o;
  endfunction

  logic [3:0]       nlen;
  hhve_pkg::scan_t  s;
  hhve_pkg::lb_t    lb_a, lb_b;
  logic             emit_a, emit_b, st_emit;
  logic [1:0]       st_code;
  logic             st_found;
  hhve_pkg::result_t res_st, res_a, res_b;

  assign nlen = (name_length > hhve_pkg::NLEN_MAX) ? hhve_pkg::NLEN_MAX : name_length;

  // Per-byte scan step
  always_comb begin
    s        = st_r;
    lb_a     = '0;
    lb_b     = '0;
    emit_a   = 1'b0;
    emit_b   = 1'b0;
    st_emit  = 1'b0;
    st_code  = hhve_pkg::ST_INCOMPLETE;
    st_found = 1'b0;
    case (st_r.phase)
      hhve_pkg::PH_DONE: begin
        if (last_byte) s = hhve_pkg::new_packet();
      end
      hhve_pkg::PH_CONFIRM: begin
        st_emit  = 1'b1;
        st_code  = hhve_pkg::ST_FOUND;
        st_found = 1'b1;
        if (last_byte) s = hhve_pkg::new_packet();
        else s.phase = hhve_pkg::PH_DONE;
      end
      hhve_pkg::PH_SCAN: begin
        if (last_byte) begin
          st_emit = 1'b1;
          st_code = (st_r.cr && data_byte == hhve_pkg::CHR_LF && st_r.pos == '0) ?
                    hhve_pkg::ST_NOT_FOUND : hhve_pkg::ST_INCOMPLETE;
          s = hhve_pkg::new_packet();
        end else if (st_r.cr && data_byte == hhve_pkg::CHR_LF) begin
          // CR LF closes the line
          s.cr = 1'b0;
          if (st_r.pos == '0) begin
            st_emit = 1'b1;
            st_code = hhve_pkg::ST_NOT_FOUND;
            s.phase = hhve_pkg::PH_DONE;
          end else if (st_r.inval || st_r.skip) begin
            s.phase = hhve_pkg::PH_CONFIRM;
          end else begin
            s.pos   = '0;
            s.nm    = 1'b1;
            s.skip  = 1'b0;
            s.inval = 1'b0;
          end
        end else begin
          // held CR turns into a line byte
          if (st_r.cr) begin
            s.cr   = 1'b0;
            lb_a   = line_byte(s, hhve_pkg::CHR_CR, name_chars, nlen);
            emit_a = lb_a.emit;
            s      = lb_a.s;
          end
          if (data_byte == hhve_pkg::CHR_CR) begin
            s.cr = 1'b1;
          end else begin
            lb_b   = line_byte(s, data_byte, name_chars, nlen);
            emit_b = lb_b.emit;
            s      = lb_b.s;
          end
        end
      end
      default: begin
        s = hhve_pkg::new_packet();
      end
    endcase
  end

  // Result formatting
  always_comb begin
    res_st.kind   = hhve_pkg::KIND_STATUS;
    res_st.vbyte  = '0;
    res_st.status = st_code;
    res_st.vlen   = st_found ? st_r.vcnt : '0;
    res_st.sat    = st_found & st_r.vtrunc;
    res_st.eor    = 1'b1;
    res_a         = '0;
    res_a.kind    = hhve_pkg::KIND_VALUE;
    res_a.vbyte   = lb_a.ch;
    res_b         = '0;
    res_b.kind    = hhve_pkg::KIND_VALUE;
    res_b.vbyte   = lb_b.ch;
  end

  assign wr_en        = accept & (st_emit | emit_a | emit_b);
  assign wr_entry.two = emit_a & emit_b;
  assign wr_entry.r0  = st_emit ? res_st : (emit_a ? res_a : res_b);
  assign wr_entry.r1  = res_b;

  assign st_nxt = accept ? s : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hhve_pkg::new_packet();
    end else begin
      st_r <= st_nxt;
    end
  end

  // Checks
  a_vcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.vcnt <= hhve_pkg::LINE_MAX)
    else $error("value count beyond line limit");

endmodule

/* design/hhve_queue.sv */
// Short entry queue between the front end and the output side.
// Depends on hhve_pkg.
`timescale 1ns / 1ps

module hhve_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  hhve_pkg::entry_t  wr_entry,
  input  logic              rd_en,
  output hhve_pkg::entry_t  head,
  output logic              head_valid,
  output logic              full
);

  hhve_pkg::entry_t            q_r [hhve_pkg::QDEPTH];
  logic [hhve_pkg::QAW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [hhve_pkg::QCW-1:0]    cnt_r, cnt_nxt;
  logic                        do_wr, do_rd;

  assign full       = (cnt_r == hhve_pkg::QCW'(hhve_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rptr_r];
  assign do_wr      = wr_en & ~full;
  assign do_rd      = rd_en & head_valid;

  // Pointer and fill update
  always_comb begin
    wptr_nxt = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) q_r[wptr_r] <= wr_entry;
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= hhve_pkg::QCW'(hhve_pkg::QDEPTH))
    else $error("queue fill above depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("entry written while queue full");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != hhve_pkg::QCW'(hhve_pkg::QDEPTH) && cnt_r != '0) |->
    (wptr_r != rptr_r))
    else $error("pointers disagree with fill count");

endmodule

/* design/hhve_back.sv */
// Output side: walks the head entry's one or two results onto the result
// ports and releases the entry. Depends on hhve_pkg.
`timescale 1ns / 1ps

module hhve_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hhve_pkg::entry_t           head,
  input  logic                       head_valid,
  output logic                       rd_en,
  input  logic                       pop,
  output logic                       empty,
  output logic                       out_item_kind,
  output logic [7:0]                 out_value_byte,
  output logic [1:0]                 out_status,
  output logic [hhve_pkg::CNT_W-1:0] out_value_length,
  output logic                       out_length_saturated,
  output logic                       out_end_of_run
);

  logic              sub_r, sub_nxt;
  logic              take;
  hhve_pkg::result_t cur;

  assign empty = ~head_valid;
  assign take  = pop & head_valid;
  assign cur   = sub_r ? head.r1 : head.r0;

  // Second half of a two-result entry, then release
  always_comb begin
    sub_nxt = sub_r;
    rd_en   = 1'b0;
    if (take) begin
      if (head.two && !sub_r) begin
        sub_nxt = 1'b1;
      end else begin
        sub_nxt = 1'b0;
        rd_en   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

  assign out_item_kind        = cur.kind;
  assign out_value_byte       = cur.vbyte;
  assign out_status           = cur.status;
  assign out_value_length     = cur.vlen;
  assign out_length_saturated = cur.sat;
  assign out_end_of_run       = cur.eor;

  // Checks
  a_sub_valid: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (head_valid && head.two))
    else $error("second result selected without a two-result entry");

endmodule

/* design/http_header_value_extract_core.sv */
// Top level of the HTTP header value extractor: configuration registers,
// front end, result queue and output side. Depends on hhve_pkg and submodules.
`timescale 1ns / 1ps
//
// Usage
//   Input: one packet byte per item on in_data_byte, in_last_byte marks the
//   packet's final byte. An item is taken on a clock edge with push high and
//   full low. Results: while empty is low the oldest result item is on the
//   out_ ports; pop high on an edge takes it. A value item carries one header
//   value byte; a status item (out_end_of_run high) ends the packet's results.
//   Config: APB-style, 64-bit data. Address 0 holds the header name bytes,
//   address 8 the name length. Write only while the block is idle.
// Timing
//   A byte is accepted every cycle while the 4-entry result queue has room.
//   Its results are written into the result queue and are shown on the out_
//   ports from the queue head. A byte that releases a held CR may give two
//   value items; the output side drains one item per cycle while pop is high.
//   When the receiver stalls, results collect in the queue and full rises
//   once all four entries are occupied; nothing is dropped.
// Reset
//   rst_n low clears the scanner to the start of a packet, empties the queue
//   and loads the default name registers.
//

module http_header_value_extract_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_last_byte,
  // result channel
  input  logic                       pop,
  output logic                       empty,
  output logic                       out_item_kind,
  output logic [7:0]                 out_value_byte,
  output logic [1:0]                 out_status,
  output logic [11:0]                out_value_length,
  output logic                       out_length_saturated,
  output logic                       out_end_of_run,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hhve_pkg::CFG_AW-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  logic [63:0]      name_chars_r;
  logic [3:0]       name_length_r;
  logic             cfg_wr;
  logic             accept;
  logic             wr_en, rd_en;
  logic             head_valid;
  hhve_pkg::entry_t wr_entry, head;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[3] == hhve_pkg::REG_NAME_LEN) ? {60'd0, name_length_r} : name_chars_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_chars_r  <= hhve_pkg::NAME_CHR_RST;
      name_length_r <= hhve_pkg::NAME_LEN_RST;
    end else if (cfg_wr) begin
      if (paddr[3] == hhve_pkg::REG_NAME_CHR) name_chars_r <= pwdata;
      else name_length_r <= pwdata[3:0];
    end
  end

  assign accept = push & ~full;

  hhve_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .last_byte   (in_last_byte),
    .name_chars  (name_chars_r),
    .name_length (name_length_r),
    .wr_en       (wr_en),
    .wr_entry    (wr_entry)
  );

  hhve_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_entry   (wr_entry),
    .rd_en      (rd_en),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  hhve_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (head),
    .head_valid           (head_valid),
    .rd_en                (rd_en),
    .pop                  (pop),
    .empty                (empty),
    .out_item_kind        (out_item_kind),
    .out_value_byte       (out_value_byte),
    .out_status           (out_status),
    .out_value_length     (out_value_length),
    .out_length_saturated (out_length_saturated),
    .out_end_of_run       (out_end_of_run)
  );

endmodule
